// ===== sv/aes_ctr_pkg.sv =====
// aes_ctr_pkg: shared types, constants and functions for the aes ctr stream cipher core
// no dependencies
`default_nettype none
package aes_ctr_pkg;

  localparam int unsigned KeyWords = 8;

  typedef enum logic [2:0] {
    CFG_KEY_SIZE  = 3'd0,
    CFG_KEY_0     = 3'd1,
    CFG_KEY_1     = 3'd2,
    CFG_KEY_2     = 3'd3,
    CFG_KEY_3     = 3'd4,
    CFG_NONCE     = 3'd5,
    CFG_BIG_END   = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_OUT
  } state_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 of the state is bits [127:120]
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127 - 8 * i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i + 4 * c] = b[i + 4 * ((c + i) % 4)];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
    return r;
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8 * i +: 8] = v[56 - 8 * i +: 8];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/aes_ctr_stream_cipher_core.sv =====
// aes_ctr_stream_cipher_core: aes counter-mode cipher, 64-bit nonce and 64-bit counter
// depends on aes_ctr_pkg
//
// One text request is taken at a time, and in_stall stays high until its result has been
// taken. A request runs a load step, then Nr rounds (10, 12 or 14) on one shared round
// unit, and its result is presented in the cycle after the last round. While out_stall is
// high the result is held; the next request can be taken from the cycle after it leaves.
// A request with message_start first runs the key schedule, one 32-bit word a cycle, and
// writes 4*(Nr+1) words (44, 52 or 60) before the block starts.
// Round keys are held in a 15 x 128 bit store that is written one word a cycle and has
// one registered read port. The key for round r+1 is read during round r.
`default_nettype none
module aes_ctr_stream_cipher_core
  import aes_ctr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        message_start,
  input  wire logic [63:0] text_high,
  input  wire logic [63:0] text_low,
  input  wire logic [4:0]  valid_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      result_high,
  output logic [63:0]      result_low,
  output logic [4:0]       result_valid_bytes
);

  logic [1:0]   key_size_mode;
  logic [63:0]  key_word [4];
  logic [63:0]  nonce_value;
  logic         counter_big_endian;

  logic [63:0]  block_counter;
  logic [3:0]   key_rounds;
  logic         key_loaded;

  state_t       state, state_next;

  logic [3:0][31:0] rk_mem [15];
  logic [5:0]   wr_idx;
  logic [31:0]  win [KeyWords];
  logic [3:0]   nk;
  logic [2:0]   phase;
  logic [3:0]   rc_idx;
  logic [7:0]   rcon;

  logic [3:0]   rd_idx;
  logic [127:0] rk_data;
  logic [127:0] rk_cur;
  logic [127:0] round_out;
  logic [3:0]   round;
  logic [127:0] st;
  logic [63:0]  text_h, text_l;
  logic [4:0]   vb;

  logic         accept;
  logic         exp_last;
  logic [31:0]  t_word;
  logic [31:0]  new_word;
  logic [5:0]   total_words;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size_mode      <= '0;
      key_word           <= '{default: '0};
      nonce_value        <= '0;
      counter_big_endian <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_SIZE: key_size_mode      <= cfg_data[1:0];
        CFG_KEY_0:    key_word[0]        <= cfg_data;
        CFG_KEY_1:    key_word[1]        <= cfg_data;
        CFG_KEY_2:    key_word[2]        <= cfg_data;
        CFG_KEY_3:    key_word[3]        <= cfg_data;
        CFG_NONCE:    nonce_value        <= cfg_data;
        CFG_BIG_END:  counter_big_endian <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rc_idx)
      4'd0: rcon = 8'h01;
      4'd1: rcon = 8'h02;
      4'd2: rcon = 8'h04;
      4'd3: rcon = 8'h08;
      4'd4: rcon = 8'h10;
      4'd5: rcon = 8'h20;
      4'd6: rcon = 8'h40;
      4'd7: rcon = 8'h80;
      4'd8: rcon = 8'h1b;
      4'd9: rcon = 8'h36;
      default: rcon = 8'h01;
    endcase
  end

  // key schedule: window holds the last nk words, oldest in win[0]
  always_comb begin
    t_word = win[nk[2:0] - 3'd1];
    if (phase == 3'd0) begin
      t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && phase == 3'd4) begin
      t_word = sub_word(t_word);
    end
    new_word = win[0] ^ t_word;
  end

  assign total_words = 6'(4 * (int'(key_rounds) + 1));
  assign exp_last    = (wr_idx == total_words - 6'd1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = message_start ? ST_EXPAND : ST_LOAD;
      ST_EXPAND: if (exp_last) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROUND;
      ST_ROUND:  if (round == key_rounds) state_next = ST_OUT;
      ST_OUT:    if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_rounds    <= 4'd10;
      key_loaded    <= 1'b0;
      block_counter <= '0;
    end else begin
      if (state == ST_IDLE && accept && message_start) begin
        key_rounds    <= (key_size_mode == 2'd0) ? 4'd10 :
                         (key_size_mode == 2'd1) ? 4'd12 : 4'd14;
        block_counter <= '0;
      end
      if (state == ST_EXPAND && exp_last) key_loaded <= 1'b1;
      if (state == ST_ROUND && round == key_rounds) begin
        if (counter_big_endian) block_counter <= block_counter + 64'd1;
        else block_counter <= swap64(swap64(block_counter) + 64'd1);
      end
    end
  end

  // expansion sequencer and memory writes
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && message_start) begin
      for (int i = 0; i < 4; i++) begin
        win[2 * i]     <= key_word[i][63:32];
        win[2 * i + 1] <= key_word[i][31:0];
      end
      nk     <= (key_size_mode == 2'd0) ? 4'd4 : (key_size_mode == 2'd1) ? 4'd6 : 4'd8;
      wr_idx <= '0;
      phase  <= '0;
      rc_idx <= '0;
    end else if (state == ST_EXPAND) begin
      rk_mem[wr_idx[5:2]][~wr_idx[1:0]] <= win[0];
      wr_idx <= wr_idx + 6'd1;
      for (int i = 0; i < KeyWords; i++) begin
        win[i] <= (i == int'(nk) - 1) ? new_word : win[(i + 1) % KeyWords];
      end
      if (phase == 3'(nk - 4'd1)) begin
        phase  <= '0;
        rc_idx <= rc_idx + 4'd1;
      end else begin
        phase <= phase + 3'd1;
      end
    end
  end

  // round key for the next step is read into a register in the cycle before that step
  always_comb begin
    rd_idx = 4'd0;
    if (state == ST_LOAD) begin
      rd_idx = 4'd1;
    end else if (state == ST_ROUND && round != key_rounds) begin
      rd_idx = round + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    rk_data <= rk_mem[rd_idx];
  end

  assign rk_cur    = key_loaded ? rk_data : 128'h0;
  assign round_out = aes_round(st, round == key_rounds) ^ rk_cur;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      text_h <= text_high;
      text_l <= text_low;
      vb     <= valid_bytes;
    end else if (state == ST_LOAD) begin
      st     <= {nonce_value, block_counter} ^ rk_cur;
      round  <= 4'd1;
    end else if (state == ST_ROUND) begin
      st     <= round_out;
      round  <= round + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROUND && round == key_rounds) begin
      result_high        <= text_h ^ round_out[127:64];
      result_low         <= text_l ^ round_out[63:0];
      result_valid_bytes <= vb;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_high) && $stable(result_low)
      && $stable(result_valid_bytes));
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall);
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> round >= 4'd1 && round <= key_rounds);
  a_rounds_legal: assert property (@(posedge clk) disable iff (rst)
    key_rounds == 4'd10 || key_rounds == 4'd12 || key_rounds == 4'd14);
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall));

endmodule
`default_nettype wire
